### rtl/tde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tde_pkg
// Shared types and constants for the trie dictionary engine.
// ----------------------------------------------------------------------------
package tde_pkg;

   localparam int MAX_NODES_DEF     = 1024;
   localparam int ALPHABET_SIZE_DEF = 26;

   localparam int SYMBOL_W     = 8;
   localparam int WORD_COUNT_W = 16;
   localparam int NODE_COUNT_W = 11;

   localparam logic [SYMBOL_W-1:0]     SYMBOL_BASE_RESET = 8'd97;
   localparam logic [WORD_COUNT_W-1:0] WORD_COUNT_MAX    = 16'hFFFF;

   // opcodes; the unused code behaves as prefix search
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_EXACT  = 2'd1;
   localparam logic [1:0] OP_PREFIX = 2'd2;

   // result error codes
   localparam logic [1:0] ERR_OK   = 2'd0;
   localparam logic [1:0] ERR_FULL = 2'd1;
   localparam logic [1:0] ERR_SYM  = 2'd2;

   typedef enum logic [1:0] {
      FAIL_NONE = 2'd0,
      FAIL_MISS = 2'd1,
      FAIL_FULL = 2'd2,
      FAIL_SYM  = 2'd3
   } fail_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_FETCH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [SYMBOL_W-1:0] symbol;
      logic                has_symbol;
      logic                last;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic [1:0]              error;
      logic [WORD_COUNT_W-1:0] word_count;
      logic [NODE_COUNT_W-1:0] node_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // item accepted: register it, read cursor row
      logic step;      // row data valid: follow or allocate a link
      logic acc_read;  // read accept flag of cursor
      logic finish;    // load result, close the word
      logic clear_wr;  // clearing pass write
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_step;    // incoming item needs a child lookup
      logic in_last;    // incoming item ends the word
      logic item_last;  // registered item ends the word
      logic clear_done; // clearing pass at its last row
      logic out_free;   // result register can take a new item
   } dp_stat_type;

endpackage
`default_nettype wire

### rtl/tde_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tde_datapath
// Child-row and accept-flag memories, word cursor, counters, config register
// and the result register.
// ----------------------------------------------------------------------------
module tde_datapath
   import tde_pkg::*;
#(
   parameter int MAX_NODES     = MAX_NODES_DEF,
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire req_type             req_data,
   input  wire logic                csr_valid,
   input  wire logic [SYMBOL_W-1:0] csr_data,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  wire ctl_cmd_type         cmd,
   output dp_stat_type              stat
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int SYM_W  = $clog2(ALPHABET_SIZE);

   typedef logic [ALPHABET_SIZE-1:0][NODE_W-1:0] row_type;

   row_type                 child_mem_ff [MAX_NODES];
   logic                    accept_mem_ff [MAX_NODES];

   row_type                 row_q_ff;
   logic                    acc_q_ff;
   req_type                 item_ff;
   logic [SYMBOL_W-1:0]     base_ff;
   logic [NODE_W-1:0]       cursor_ff, cursor_in;
   fail_type                fail_ff, fail_in;
   logic [CNT_W-1:0]        nodes_ff, nodes_in;
   logic [WORD_COUNT_W-1:0] words_ff, words_in;
   logic [NODE_W-1:0]       clr_cnt_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [SYMBOL_W-1:0]     sym_idx;
   logic [SYM_W-1:0]        sym_sel;
   logic                    sym_bad;
   logic [NODE_W-1:0]       link;
   logic                    pool_full;
   logic                    alloc;
   row_type                 row_wdata;
   logic                    row_we;
   logic [NODE_W-1:0]       row_waddr;
   logic                    acc_we;
   logic                    acc_wdata;
   logic                    ins_ok;

   assign sym_idx   = item_ff.symbol - base_ff;
   assign sym_bad   = {1'b0, sym_idx} >= (SYMBOL_W + 1)'(ALPHABET_SIZE);
   assign sym_sel   = sym_idx[SYM_W-1:0];
   assign link      = row_q_ff[sym_sel];
   assign pool_full = nodes_ff >= CNT_W'(MAX_NODES);
   assign alloc     = cmd.step && !sym_bad && (link == '0) &&
                      (item_ff.opcode == OP_INSERT) && !pool_full;

   always_comb begin
      row_wdata          = row_q_ff;
      row_wdata[sym_sel] = nodes_ff[NODE_W-1:0];
      if (cmd.clear_wr) begin
         row_wdata = '0;
      end
   end

   assign row_we    = cmd.clear_wr || alloc;
   assign row_waddr = cmd.clear_wr ? clr_cnt_ff : cursor_ff;

   // child rows: one read or one write a cycle
   always_ff @(posedge clock) begin
      if (row_we) begin
         child_mem_ff[row_waddr] <= row_wdata;
      end
      if (cmd.capture) begin
         row_q_ff <= child_mem_ff[cursor_ff];
      end
   end

   assign ins_ok    = (fail_ff == FAIL_NONE) && (item_ff.opcode == OP_INSERT);
   assign acc_we    = cmd.clear_wr || (cmd.finish && ins_ok);
   assign acc_wdata = !cmd.clear_wr;

   always_ff @(posedge clock) begin
      if (acc_we) begin
         accept_mem_ff[row_waddr] <= acc_wdata;
      end
      if (cmd.acc_read) begin
         acc_q_ff <= accept_mem_ff[cursor_ff];
      end
   end

   always_comb begin
      cursor_in   = cursor_ff;
      fail_in     = fail_ff;
      nodes_in    = nodes_ff;
      words_in    = words_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.step) begin
         if (sym_bad) begin
            fail_in = FAIL_SYM;
         end else if (link != '0) begin
            cursor_in = link;
         end else if (item_ff.opcode != OP_INSERT) begin
            fail_in = FAIL_MISS;
         end else if (pool_full) begin
            fail_in = FAIL_FULL;
         end else begin
            cursor_in = nodes_ff[NODE_W-1:0];
            nodes_in  = nodes_ff + CNT_W'(1);
         end
      end
      if (cmd.finish) begin
         rsp_data_in.found = 1'b0;
         rsp_data_in.error = ERR_OK;
         case (fail_ff)
            FAIL_FULL: rsp_data_in.error = ERR_FULL;
            FAIL_SYM:  rsp_data_in.error = ERR_SYM;
            FAIL_NONE: begin
               if (item_ff.opcode == OP_INSERT) begin
                  rsp_data_in.found = 1'b1;
                  if (words_ff != WORD_COUNT_MAX) begin
                     words_in = words_ff + WORD_COUNT_W'(1);
                  end
               end else if (item_ff.opcode == OP_EXACT) begin
                  rsp_data_in.found = acc_q_ff;
               end else begin
                  rsp_data_in.found = 1'b1;
               end
            end
            default: rsp_data_in.found = 1'b0;
         endcase
         rsp_data_in.word_count = words_in;
         rsp_data_in.node_count = NODE_COUNT_W'(nodes_ff);
         cursor_in              = '0;
         fail_in                = FAIL_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= SYMBOL_BASE_RESET;
         cursor_ff    <= '0;
         fail_ff      <= FAIL_NONE;
         nodes_ff     <= CNT_W'(1);
         words_ff     <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            base_ff <= csr_data;
         end
         cursor_ff <= cursor_in;
         fail_ff   <= fail_in;
         nodes_ff  <= nodes_in;
         words_ff  <= words_in;
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + NODE_W'(1);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.in_step    = req_data.has_symbol && (fail_ff == FAIL_NONE);
   assign stat.in_last    = req_data.last;
   assign stat.item_last  = item_ff.last;
   assign stat.clear_done = clr_cnt_ff == NODE_W'(MAX_NODES - 1);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### rtl/tde_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tde_controller
// Sequencer: clearing pass, item intake, child lookup, result hand-off.
// ----------------------------------------------------------------------------
module tde_controller
   import tde_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire dp_stat_type stat,
   output ctl_cmd_type      cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (stat.in_step) begin
                  state_in = ST_STEP;
               end else if (stat.in_last) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = stat.item_last ? ST_FETCH : ST_IDLE;
         end
         ST_FETCH: begin
            cmd.acc_read = 1'b1;
            state_in     = ST_RESULT;
         end
         ST_RESULT: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule
`default_nettype wire

### rtl/trie_dictionary_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trie_dictionary_engine_core
// Trie dictionary: insert, exact search and prefix search, one symbol per item.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the child-row and accept
// memories, one node row per cycle, during which req_ready is low (csr
// writes are taken at any time). A symbol item that is looked up goes
// through intake with the read of the cursor's child row, then the link
// follow or new-node write into the same single-port row memory. An item
// without a lookup has only the intake step. An item marked last adds the
// accept-flag read and the load of the result register, which waits while
// an earlier result is untaken; a result waits there while rsp_ready is low.
// ----------------------------------------------------------------------------
module trie_dictionary_engine_core
   import tde_pkg::*;
#(
   parameter int MAX_NODES     = MAX_NODES_DEF,
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [SYMBOL_W-1:0] csr_data
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   tde_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tde_datapath #(
      .MAX_NODES     (MAX_NODES),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

   // no intake while the memories are being cleared
   a_no_req_during_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> !req_ready)
      else $error("item taken during clearing pass");

   // a result appears only after the controller finished a word
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result without finish");

   // finishing must not overwrite a result still waiting
   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> stat.out_free)
      else $error("result overwritten");

   // single row port: lookup read and link update never coincide
   a_row_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && (cmd.step || cmd.clear_wr)))
      else $error("row memory port conflict");

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for trie_dictionary_engine_core. A directed table covers empty
// words, bad symbols, misses, mixed opcodes and the spare opcode. Random word
// traffic then runs under several symbol_base settings, followed by a few long
// insert words over the whole alphabet. Directed rows with an expected entry
// are checked against it and all other results against a local trie model,
// with random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_top;
   import tde_pkg::*;

   localparam int NODES       = MAX_NODES_DEF;
   localparam int ALPHA       = ALPHABET_SIZE_DEF;
   localparam int NODE_W      = $clog2(NODES);
   localparam int CLK_HALF    = 10;
   localparam int MAX_GAP     = 11;
   localparam int SETTLE      = 12;
   localparam int STALL_LIMIT = 6000;
   localparam int PRINT_CAP   = 40;

   // no package name for the fourth opcode; the block treats it as prefix search
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } stim_row_type;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [SYMBOL_W-1:0] csr_data  = '0;

   // trie model state
   logic [NODE_W-1:0]       trie_link [NODES*ALPHA];
   bit                      word_end  [NODES];
   int                      node_total;
   logic [WORD_COUNT_W-1:0] words_total;
   logic [NODE_W-1:0]       walk_node;
   fail_type                walk_fail;
   logic [SYMBOL_W-1:0]     sym_base;

   rsp_type      rsp_expect [$];
   stim_row_type dir_rows [$];
   int           items_sent   = 0;
   int           results_seen = 0;
   int           errors       = 0;
   int           bases_used   = 0;
   int           dir_items    = 0;
   int           quiet        = 0;
   rsp_type      want_rsp;

   trie_dictionary_engine_core #(
      .MAX_NODES     (NODES),
      .ALPHABET_SIZE (ALPHA)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   task automatic trie_clear;
      for (int i = 0; i < NODES*ALPHA; i++) trie_link[i] = '0;
      for (int i = 0; i < NODES; i++) word_end[i] = 1'b0;
      node_total  = 1;
      words_total = '0;
      walk_node   = '0;
      walk_fail   = FAIL_NONE;
      sym_base    = SYMBOL_BASE_RESET;
   endtask

   // walk one symbol, and on the last item of a word build its result
   task automatic trie_predict(input req_type it, output bit gives, output rsp_type r);
      logic [SYMBOL_W-1:0] idx;
      int                  slot;
      logic [NODE_W-1:0]   nxt;
      gives = 1'b0;
      r     = '0;
      if (it.has_symbol && walk_fail == FAIL_NONE) begin
         idx = it.symbol - sym_base;
         if (int'(idx) >= ALPHA) begin
            walk_fail = FAIL_SYM;
         end else begin
            slot = int'(walk_node) * ALPHA + int'(idx);
            nxt  = trie_link[slot];
            if (nxt != '0) begin
               walk_node = nxt;
            end else if (it.opcode != OP_INSERT) begin
               walk_fail = FAIL_MISS;
            end else if (node_total >= NODES) begin
               walk_fail = FAIL_FULL;
            end else begin
               trie_link[slot] = NODE_W'(node_total);
               walk_node       = NODE_W'(node_total);
               node_total++;
            end
         end
      end
      if (it.last) begin
         gives = 1'b1;
         case (walk_fail)
            FAIL_FULL: r.error = ERR_FULL;
            FAIL_SYM:  r.error = ERR_SYM;
            FAIL_NONE: begin
               r.error = ERR_OK;
               if (it.opcode == OP_INSERT) begin
                  word_end[walk_node] = 1'b1;
                  if (words_total != WORD_COUNT_MAX) words_total++;
                  r.found = 1'b1;
               end else if (it.opcode == OP_EXACT) begin
                  r.found = word_end[walk_node];
               end else begin
                  r.found = 1'b1;
               end
            end
            default: r.error = ERR_OK;
         endcase
         r.word_count = words_total;
         r.node_count = NODE_COUNT_W'(node_total);
         walk_node    = '0;
         walk_fail    = FAIL_NONE;
      end
   endtask

   function automatic stim_row_type dir_row(logic [1:0] op, logic [SYMBOL_W-1:0] sym,
                                            logic has, logic last, logic typed, logic fnd,
                                            logic [1:0] err, int wc, int nc);
      stim_row_type r;
      r.item.opcode     = op;
      r.item.symbol     = sym;
      r.item.has_symbol = has;
      r.item.last       = last;
      r.typed           = typed;
      r.want.found      = fnd;
      r.want.error      = err;
      r.want.word_count = WORD_COUNT_W'(wc);
      r.want.node_count = NODE_COUNT_W'(nc);
      return r;
   endfunction

   task automatic add_row(input stim_row_type r);
      dir_rows = {dir_rows, r};
   endtask

   task automatic send_item(input req_type it, input bit typed, input rsp_type want);
      int      gap;
      bit      gives;
      rsp_type pred;
      gap = $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      trie_predict(it, gives, pred);
      if (gives) rsp_expect = {rsp_expect, (typed ? want : pred)};
      items_sent++;
   endtask

   task automatic settle;
      req_valid <= 1'b0;
      while (rsp_expect.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_base(input logic [SYMBOL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sym_base = value;
      bases_used++;
   endtask

   // one word; fill mode inserts long words over the whole alphabet
   task automatic play_word(input bit fill);
      int         len;
      int         span;
      int         pick;
      bit         mixed;
      logic [1:0] op;
      req_type    it;
      mixed = 1'b0;
      span  = ALPHA - 1;
      if (fill) begin
         op  = OP_INSERT;
         len = $urandom_range(6, 14);
      end else begin
         pick = $urandom_range(0, 9);
         if (pick < 4) op = OP_INSERT;
         else if (pick < 6) op = OP_EXACT;
         else if (pick < 8) op = OP_PREFIX;
         else if (pick == 8) op = OP_SPARE;
         else begin
            op    = OP_INSERT;
            mixed = 1'b1;
         end
         len = $urandom_range(0, 5);
         // a narrow alphabet makes searches hit often
         if ($urandom_range(0, 2) != 0) span = 3;
      end
      if (len == 0) begin
         it.opcode     = op;
         it.symbol     = SYMBOL_W'($urandom);
         it.has_symbol = 1'b0;
         it.last       = 1'b1;
         send_item(it, 1'b0, '0);
      end
      for (int i = 0; i < len; i++) begin
         pick          = $urandom_range(0, 19);
         it.opcode     = mixed ? 2'($urandom_range(0, 3)) : op;
         it.symbol     = (!fill && pick == 0) ? SYMBOL_W'($urandom)
                                              : sym_base + SYMBOL_W'($urandom_range(0, span));
         it.has_symbol = fill || pick != 1;
         it.last       = (i == len - 1);
         send_item(it, 1'b0, '0);
      end
   endtask

   task automatic mixed_phase(input logic [SYMBOL_W-1:0] value, input int count);
      int start;
      settle();
      write_base(value);
      start = items_sent;
      while (items_sent - start < count) play_word(1'b0);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         if (errors <= PRINT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_expect.size() == 0) begin
            errors++;
            if (errors <= PRINT_CAP)
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
         end else begin
            want_rsp = rsp_expect.pop_front();
            check_field("found", int'(want_rsp.found), int'(rsp_data.found));
            check_field("error", int'(want_rsp.error), int'(rsp_data.error));
            check_field("word_count", int'(want_rsp.word_count), int'(rsp_data.word_count));
            check_field("node_count", int'(want_rsp.node_count), int'(rsp_data.node_count));
         end
      end
   end

   // response side stalls
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // covers the clearing pass after reset as well
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("trie_dictionary_engine_core verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      trie_clear();

      // directed part at the reset symbol_base
      add_row(dir_row(OP_EXACT,  8'h00, 0, 1, 1, 0, ERR_OK, 0, 1));
      add_row(dir_row(OP_PREFIX, 8'hFF, 0, 1, 1, 1, ERR_OK, 0, 1));
      add_row(dir_row(OP_INSERT, "a",   1, 1, 1, 1, ERR_OK, 1, 2));
      add_row(dir_row(OP_INSERT, "z",   1, 0, 0, 0, ERR_OK, 0, 0));
      add_row(dir_row(OP_INSERT, "z",   1, 1, 1, 1, ERR_OK, 2, 4));
      add_row(dir_row(OP_EXACT,  "z",   1, 1, 1, 0, ERR_OK, 2, 4));
      add_row(dir_row(OP_PREFIX, "z",   1, 1, 1, 1, ERR_OK, 2, 4));
      add_row(dir_row(OP_EXACT,  "z",   1, 0, 0, 0, ERR_OK, 0, 0));
      add_row(dir_row(OP_EXACT,  "z",   1, 1, 1, 1, ERR_OK, 2, 4));
      add_row(dir_row(OP_EXACT,  "b",   1, 1, 1, 0, ERR_OK, 2, 4));
      // symbols just past the alphabet and at both byte extremes
      add_row(dir_row(OP_INSERT, "{",   1, 1, 1, 0, ERR_SYM, 2, 4));
      add_row(dir_row(OP_INSERT, 8'hFF, 1, 1, 1, 0, ERR_SYM, 2, 4));
      add_row(dir_row(OP_PREFIX, 8'h00, 1, 1, 1, 0, ERR_SYM, 2, 4));
      // empty word marks the root
      add_row(dir_row(OP_INSERT, 8'h00, 0, 1, 1, 1, ERR_OK, 3, 4));
      add_row(dir_row(OP_EXACT,  8'h5A, 0, 1, 1, 1, ERR_OK, 3, 4));
      add_row(dir_row(OP_SPARE,  "a",   1, 1, 1, 1, ERR_OK, 3, 4));
      // insert ending after a search miss marks nothing
      add_row(dir_row(OP_EXACT,  "q",   1, 0, 0, 0, ERR_OK, 0, 0));
      add_row(dir_row(OP_INSERT, "r",   1, 1, 1, 0, ERR_OK, 3, 4));
      add_row(dir_row(OP_INSERT, "c",   1, 0, 0, 0, ERR_OK, 0, 0));
      add_row(dir_row(OP_EXACT,  "d",   1, 1, 1, 0, ERR_OK, 3, 5));
      add_row(dir_row(OP_INSERT, "a",   1, 0, 0, 0, ERR_OK, 0, 0));
      add_row(dir_row(OP_INSERT, 8'hAA, 0, 0, 0, 0, ERR_OK, 0, 0));
      add_row(dir_row(OP_INSERT, "b",   1, 1, 0, 0, ERR_OK, 0, 0));
      add_row(dir_row(OP_PREFIX, "~",   1, 0, 0, 0, ERR_OK, 0, 0));
      add_row(dir_row(OP_PREFIX, "a",   1, 1, 1, 0, ERR_SYM, 4, 6));
      foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      dir_items = items_sent;

      // random traffic under several alphabet offsets
      mixed_phase(8'h00, 80);
      mixed_phase(8'hFF, 80);
      mixed_phase(8'h41, 80);
      mixed_phase(SYMBOL_W'($urandom), 80);
      mixed_phase(SYMBOL_BASE_RESET, 40);

      // a few deep insert words over the whole alphabet
      repeat (6) play_word(1'b1);

      settle();
      $display("Ran %0d items (%0d directed), %0d results checked, %0d symbol_base writes",
               items_sent, dir_items, results_seen, bases_used);
      $display("Trie ended with %0d nodes and a word count of %0d", node_total, words_total);
      if (errors == 0) begin
         $display("trie_dictionary_engine_core verification clean");
      end else begin
         $display("trie_dictionary_engine_core verification failed");
      end
      $finish;
   end

endmodule

### trie_dictionary_engine_core.f
rtl/tde_pkg.sv
rtl/tde_datapath.sv
rtl/tde_controller.sv
rtl/trie_dictionary_engine_core.sv
sim/tb_top.sv
